### hdl/wdt_pkg.sv
// wdt_pkg: shared constants and types for the byte-wide watchdog register core
// opcodes, register offsets and control byte bit positions
// no dependencies
`default_nettype none
package wdt_pkg;

  localparam int COUNT_BITS = 24;
  localparam logic [31:0] MAX_COUNTER = 32'h00FF_FFFF;
  // seed bits that can ever be set: counter width and the 24-bit register limit
  localparam logic [31:0] CNT_MASK32 = (COUNT_BITS == 32) ? 32'hFFFF_FFFF
                                       : ((32'd1 << COUNT_BITS) - 32'd1);
  localparam logic [COUNT_BITS-1:0] SEED_MASK =
    COUNT_BITS'(CNT_MASK32 & MAX_COUNTER);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_NONE    = 3'd0,
    REG_CONTROL = 3'd1,
    REG_CAPT_HI = 3'd2,
    REG_CAPT_MD = 3'd3,
    REG_CAPT_LO = 3'd4,
    REG_SEED_HI = 3'd5,
    REG_SEED_MD = 3'd6,
    REG_SEED_LO = 3'd7
  } reg_offset_t;

  // control byte bit positions
  localparam int CB_MODE    = 7;
  localparam int CB_INT     = 6;
  localparam int CB_RST_ACT = 5;
  localparam int CB_PET     = 4;
  localparam int CB_RUN     = 3;
  localparam int CB_CAPT    = 2;
  localparam int CB_RESET   = 1;
  localparam int CB_ALARM   = 0;

  // byte of a counter-wide value, bits above the counter read as zero
  function automatic logic [7:0] byte_of(input logic [COUNT_BITS-1:0] v,
                                         input logic [1:0] idx);
    logic [31:0] wide;
    wide = 32'(v);
    case (idx)
      2'd2:    byte_of = wide[23:16];
      2'd1:    byte_of = wide[15:8];
      2'd0:    byte_of = wide[7:0];
      default: byte_of = 8'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

### hdl/watchdog_timer_registers_core.sv
// watchdog_timer_registers_core: byte-wide register-mapped watchdog timer
// decodes register reads, writes and timer ticks into one result register
// depends on wdt_pkg
//
// the result is valid in the cycle after input acceptance
// throughput: one item per cycle; the single result register is refilled
//   in the cycle it is taken, so input stalls only while a result waits
// reset: synchronous, active high; boot mode set, all other state cleared, result word not reset
`default_nettype none
module watchdog_timer_registers_core
  import wdt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] opcode,
  input  wire logic [2:0] reg_offset,
  input  wire logic [7:0] write_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      read_byte,
  output logic            irq_level,
  output logic            system_reset_pulse
);

  logic                  boot_mode, boot_mode_next;
  logic                  act_interrupt, act_interrupt_next;
  logic                  act_reset, act_reset_next;
  logic                  running, running_next;
  logic                  alarm, alarm_next;
  logic [COUNT_BITS-1:0] seed, seed_next;
  logic [COUNT_BITS-1:0] count, count_next;
  logic [COUNT_BITS-1:0] captured, captured_next;
  logic [7:0]            rd_next;
  logic                  pulse_next;
  logic [7:0]            ctrl_byte;
  logic                  accept;
  logic                  alarm_w;
  logic [COUNT_BITS-1:0] seed_w;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctrl_byte = 8'd0;
    ctrl_byte[CB_MODE]    = boot_mode;
    ctrl_byte[CB_INT]     = act_interrupt;
    ctrl_byte[CB_RST_ACT] = act_reset;
    ctrl_byte[CB_RUN]     = running;
    ctrl_byte[CB_ALARM]   = alarm;
  end

  always_comb begin
    boot_mode_next     = boot_mode;
    act_interrupt_next = act_interrupt;
    act_reset_next     = act_reset;
    running_next       = running;
    alarm_next         = alarm;
    seed_next          = seed;
    count_next         = count;
    captured_next      = captured;
    rd_next            = 8'd0;
    pulse_next         = 1'b0;
    alarm_w            = alarm;
    seed_w             = seed;

    case (opcode_t'(opcode))
      OP_READ: begin
        case (reg_offset_t'(reg_offset))
          REG_CONTROL: rd_next = ctrl_byte;
          REG_CAPT_HI: rd_next = byte_of(captured, 2'd2);
          REG_CAPT_MD: rd_next = byte_of(captured, 2'd1);
          REG_CAPT_LO: rd_next = byte_of(captured, 2'd0);
          REG_SEED_HI: rd_next = byte_of(seed, 2'd2);
          REG_SEED_MD: rd_next = byte_of(seed, 2'd1);
          REG_SEED_LO: rd_next = byte_of(seed, 2'd0);
          default:     rd_next = 8'd0;
        endcase
      end
      OP_WRITE: begin
        case (reg_offset_t'(reg_offset))
          REG_CONTROL: begin
            act_interrupt_next = write_byte[CB_INT];
            act_reset_next     = write_byte[CB_RST_ACT];
            if (write_byte[CB_RESET]) begin
              running_next = 1'b0;
              alarm_next   = 1'b0;
              alarm_w      = 1'b0;
              if (write_byte[CB_MODE]) begin
                boot_mode_next = 1'b0;
              end
            end
            // pet is refused while the alarm stands, after any reset above
            if (write_byte[CB_PET] && !alarm_w) begin
              count_next   = seed;
              running_next = 1'b1;
            end
            // capture sees the count after any pet in the same word
            if (write_byte[CB_CAPT]) begin
              captured_next = count_next;
            end
          end
          REG_SEED_HI, REG_SEED_MD, REG_SEED_LO: begin
            if (!running) begin
              seed_w = seed;
              case (reg_offset_t'(reg_offset))
                REG_SEED_HI: seed_w = COUNT_BITS'((32'(seed) & ~32'h00FF_0000)
                                      | (32'(write_byte) << 16));
                REG_SEED_MD: seed_w = COUNT_BITS'((32'(seed) & ~32'h0000_FF00)
                                      | (32'(write_byte) << 8));
                default:     seed_w = COUNT_BITS'((32'(seed) & ~32'h0000_00FF)
                                      | 32'(write_byte));
              endcase
              seed_next = seed_w & SEED_MASK;
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (running) begin
          if (count != '0) begin
            count_next = count - COUNT_BITS'(1);
          end
          // alarm when the count lands on zero or was already there
          if (count == '0 || count == COUNT_BITS'(1)) begin
            alarm_next   = 1'b1;
            running_next = 1'b0;
            pulse_next   = act_reset;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_mode     <= 1'b1;
      act_interrupt <= 1'b0;
      act_reset     <= 1'b0;
      running       <= 1'b0;
      alarm         <= 1'b0;
      seed          <= '0;
      count         <= '0;
      captured      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        boot_mode     <= boot_mode_next;
        act_interrupt <= act_interrupt_next;
        act_reset     <= act_reset_next;
        running       <= running_next;
        alarm         <= alarm_next;
        seed          <= seed_next;
        count         <= count_next;
        captured      <= captured_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      read_byte          <= rd_next;
      irq_level          <= alarm_next && act_interrupt_next;
      system_reset_pulse <= pulse_next;
    end
  end

  a_alarm_stops_timer : assert property (@(posedge clk) disable iff (rst)
    alarm |-> !running)
    else $error("alarm set while timer running");

  a_irq_tracks_state : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (irq_level == (alarm && act_interrupt)))
    else $error("irq level disagrees with alarm state");

  a_pulse_needs_alarm : assert property (@(posedge clk) disable iff (rst)
    (out_valid && system_reset_pulse) |-> (alarm && act_reset && !running))
    else $error("reset pulse without alarm and reset action");

  a_pulse_on_alarm_rise : assert property (@(posedge clk) disable iff (rst)
    $past(accept) && system_reset_pulse |-> !$past(alarm))
    else $error("reset pulse while alarm already stood");

  a_seed_frozen : assert property (@(posedge clk) disable iff (rst)
    $past(running) && !$past(rst) |-> seed == $past(seed))
    else $error("seed changed while running");

endmodule
`default_nettype wire
